[src/signed_wasserstein2_1d_assert.svh]
`ifndef SIGNED_WASSERSTEIN2_1D_ASSERT_SVH
`define SIGNED_WASSERSTEIN2_1D_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SW2_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SW2_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/sw2_pkg.sv]
`timescale 1ns / 1ps
package sw2_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int VALUE_DEF     = 16;
    localparam int WFRAC_DEF     = 24;
    localparam int WRAW_BITS     = 15;
    localparam int COST_BITS     = 32;

    localparam logic [1:0] KIND_LOAD_REF = 2'd0;
    localparam logic [1:0] KIND_LOAD_OTH = 2'd1;
    localparam logic [1:0] KIND_COMPUTE  = 2'd2;

    typedef struct packed {
        logic set_sel;
        logic neg;
        logic rd_raw;
        logic rd_norm;
        logic div_start;
        logic wr_norm;
        logic lat_i;
        logic cmp_j;
        logic earlier;
        logic wr_sorted;
        logic mw_init;
        logic mw_rd;
        logic mw_lat;
        logic mw_step;
        logic mw_mac;
        logic save_plain;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic adv_a;
        logic adv_b;
        logic out_free;
    } stat_t;

endpackage

[src/sw2_dp.sv]
`timescale 1ns / 1ps
module sw2_dp
    import sw2_pkg::*;
#(
    parameter int SET_DEPTH        = DEPTH_DEF,
    parameter int VALUE_BITS       = VALUE_DEF,
    parameter int WEIGHT_FRAC_BITS = WFRAC_DEF,
    localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1,
    localparam int CW = $clog2(SET_DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_accept,
    input  logic [1:0]    in_kind,
    input  logic [15:0]   in_value,
    input  logic [15:0]   in_weight,
    input  cmd_t          cmd,
    input  logic [AW-1:0] addr_a,
    input  logic [AW-1:0] addr_b,
    output stat_t         stat,
    output logic [CW-1:0] ref_cnt,
    output logic [CW-1:0] oth_cnt,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata,
    output logic [1:0]    m_tuser
);

    localparam int VB   = VALUE_BITS;
    localparam int F    = WEIGHT_FRAC_BITS;
    localparam int SW   = WRAW_BITS + CW;
    localparam int NW   = WRAW_BITS + F;
    localparam int NCW  = $clog2(NW + 1);
    localparam int QW   = F + 1;
    localparam int RW   = VB + WRAW_BITS;
    localparam int XW   = VB + 1;
    localparam int DW   = VB + 2;
    localparam int SQW  = 2 * VB + 2;
    localparam int ACW  = 2 * VB + F + 2;
    localparam int PW   = SQW + QW;
    localparam int TW   = VB + QW;

    logic [RW-1:0] raw_ref [SET_DEPTH];
    logic [RW-1:0] raw_oth [SET_DEPTH];
    logic [QW-1:0] nrm_ref [SET_DEPTH];
    logic [QW-1:0] nrm_oth [SET_DEPTH];
    logic [TW-1:0] srt_ref [SET_DEPTH];
    logic [TW-1:0] srt_oth [SET_DEPTH];

    logic [RW-1:0] raw_ref_q, raw_oth_q;
    logic [QW-1:0] nrm_ref_q, nrm_oth_q;
    logic [TW-1:0] srt_ref_q, srt_oth_q;

    logic [CW-1:0] ref_cnt_reg, oth_cnt_reg;
    logic [SW-1:0] ref_sum_reg, oth_sum_reg;
    logic          drop_reg;

    logic [31:0]          v32;
    logic [VB-1:0]        load_val;
    logic [WRAW_BITS-1:0] load_wt;
    logic [RW-1:0]        load_word;

    assign v32       = {16'b0, in_value};
    assign load_val  = v32[VB-1:0];
    assign load_wt   = in_weight[15] ? '0 : in_weight[WRAW_BITS-1:0];
    assign load_word = {load_val, load_wt};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_cnt_reg <= '0;
            oth_cnt_reg <= '0;
            ref_sum_reg <= '0;
            oth_sum_reg <= '0;
            drop_reg    <= 1'b0;
        end
        else if (cmd.emit)
        begin
            ref_cnt_reg <= '0;
            oth_cnt_reg <= '0;
            ref_sum_reg <= '0;
            oth_sum_reg <= '0;
            drop_reg    <= 1'b0;
        end
        else if (in_accept && in_kind == KIND_LOAD_REF)
        begin
            if (ref_cnt_reg >= CW'(SET_DEPTH))
                drop_reg <= 1'b1;
            else
            begin
                ref_cnt_reg <= ref_cnt_reg + 1'b1;
                ref_sum_reg <= ref_sum_reg + SW'(load_wt);
            end
        end
        else if (in_accept && in_kind == KIND_LOAD_OTH)
        begin
            if (oth_cnt_reg >= CW'(SET_DEPTH))
                drop_reg <= 1'b1;
            else
            begin
                oth_cnt_reg <= oth_cnt_reg + 1'b1;
                oth_sum_reg <= oth_sum_reg + SW'(load_wt);
            end
        end
    end

    assign ref_cnt = ref_cnt_reg;
    assign oth_cnt = oth_cnt_reg;

    // Raw sample memories: written by loads, read during normalize and sort.
    always_ff @(posedge clk)
    begin
        if (in_accept && in_kind == KIND_LOAD_REF && ref_cnt_reg < CW'(SET_DEPTH))
            raw_ref[ref_cnt_reg[AW-1:0]] <= load_word;
        if (cmd.rd_raw)
            raw_ref_q <= raw_ref[addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && in_kind == KIND_LOAD_OTH && oth_cnt_reg < CW'(SET_DEPTH))
            raw_oth[oth_cnt_reg[AW-1:0]] <= load_word;
        if (cmd.rd_raw)
            raw_oth_q <= raw_oth[addr_a];
    end

    logic [RW-1:0]        raw_sel;
    logic signed [VB-1:0] raw_x;
    logic [WRAW_BITS-1:0] raw_w;

    assign raw_sel = cmd.set_sel ? raw_oth_q : raw_ref_q;
    assign raw_x   = raw_sel[RW-1:WRAW_BITS];
    assign raw_w   = raw_sel[WRAW_BITS-1:0];

    // Restoring divider, one quotient bit per cycle.
    logic [NW-1:0]  dvd_reg;
    logic [SW-1:0]  dsr_reg;
    logic [SW-1:0]  rem_reg;
    logic [NCW-1:0] dcnt_reg;
    logic           dbusy_reg;
    logic [SW:0]    trial;
    logic [SW-1:0]  set_sum;

    assign set_sum = cmd.set_sel ? oth_sum_reg : ref_sum_reg;
    assign trial   = {rem_reg, dvd_reg[NW-1]} - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= NCW'(NW);
        end
        else if (cmd.wr_norm)
            dbusy_reg <= 1'b0;
        else if (dbusy_reg && dcnt_reg != '0)
            dcnt_reg <= dcnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dvd_reg <= {raw_w, {F{1'b0}}};
            dsr_reg <= (set_sum == '0) ? SW'(1) : set_sum;
            rem_reg <= '0;
        end
        else if (dbusy_reg && dcnt_reg != '0)
        begin
            if (!trial[SW])
            begin
                rem_reg <= trial[SW-1:0];
                dvd_reg <= {dvd_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[SW-2:0], dvd_reg[NW-1]};
                dvd_reg <= {dvd_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign stat.div_done = dbusy_reg && dcnt_reg == '0;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_norm && !cmd.set_sel)
            nrm_ref[addr_a] <= dvd_reg[QW-1:0];
        if (cmd.rd_norm)
            nrm_ref_q <= nrm_ref[addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_norm && cmd.set_sel)
            nrm_oth[addr_a] <= dvd_reg[QW-1:0];
        if (cmd.rd_norm)
            nrm_oth_q <= nrm_oth[addr_a];
    end

    // Rank sort: each sample's slot is the count of samples ordered ahead of it.
    logic signed [VB-1:0] xi_reg;
    logic [QW-1:0]        wi_reg;
    logic [AW-1:0]        rank_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.lat_i)
        begin
            xi_reg   <= raw_x;
            wi_reg   <= cmd.set_sel ? nrm_oth_q : nrm_ref_q;
            rank_reg <= '0;
        end
        else if (cmd.cmp_j)
        begin
            if (raw_x < xi_reg || (raw_x == xi_reg && cmd.earlier))
                rank_reg <= rank_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_sorted && !cmd.set_sel)
            srt_ref[rank_reg] <= {xi_reg, wi_reg};
        if (cmd.mw_rd)
            srt_ref_q <= srt_ref[addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_sorted && cmd.set_sel)
            srt_oth[rank_reg] <= {xi_reg, wi_reg};
        if (cmd.mw_rd)
            srt_oth_q <= srt_oth[addr_b];
    end

    // Merge walk.
    logic signed [XW-1:0] xa_reg, xb_reg;
    logic [QW-1:0]        wa_reg, wb_reg, m_reg;
    logic                 lda_reg, ldb_reg;
    logic [SQW-1:0]       sq_reg;
    logic [ACW-1:0]       acc_reg, plain_reg;
    logic signed [XW-1:0] xa_new, xb_raw;
    logic signed [DW-1:0] dx;
    logic [XW-1:0]        mag;
    logic [SQW-1:0]       mag_sq;
    logic [QW-1:0]        m_min;
    logic [PW-1:0]        prod;

    assign xa_new = XW'($signed(srt_ref_q[TW-1:QW]));
    assign xb_raw = XW'($signed(srt_oth_q[TW-1:QW]));
    assign dx     = DW'(xa_reg) - DW'(xb_reg);
    assign mag    = dx[DW-1] ? XW'(-dx) : XW'(dx);
    assign mag_sq = mag * mag;
    assign m_min  = (wa_reg < wb_reg) ? wa_reg : wb_reg;
    assign prod   = PW'(sq_reg) * PW'(m_reg);

    assign stat.adv_a = wa_reg <= wb_reg;
    assign stat.adv_b = wb_reg <= wa_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mw_init)
        begin
            acc_reg <= '0;
            lda_reg <= 1'b1;
            ldb_reg <= 1'b1;
        end
        if (cmd.mw_lat)
        begin
            if (lda_reg)
            begin
                xa_reg <= xa_new;
                wa_reg <= srt_ref_q[QW-1:0];
            end
            if (ldb_reg)
            begin
                xb_reg <= cmd.neg ? -xb_raw : xb_raw;
                wb_reg <= srt_oth_q[QW-1:0];
            end
        end
        if (cmd.mw_step)
        begin
            m_reg   <= m_min;
            sq_reg  <= mag_sq;
            wa_reg  <= wa_reg - m_min;
            wb_reg  <= wb_reg - m_min;
            lda_reg <= stat.adv_a;
            ldb_reg <= stat.adv_b;
        end
        if (cmd.mw_mac)
            acc_reg <= acc_reg + ACW'(prod);
        if (cmd.save_plain)
            plain_reg <= acc_reg;
    end

    // Result: the smaller cost, plain set on a tie, shifted to an unsigned Q32.0 integer, saturating.
    logic                 take_neg;
    logic [ACW-1:0]       chosen;
    logic [ACW+31:0]      shifted;
    logic [COST_BITS-1:0] cost;

    assign take_neg = acc_reg < plain_reg;
    assign chosen   = take_neg ? acc_reg : plain_reg;
    assign shifted  = {32'b0, chosen} >> F;
    assign cost     = (|shifted[ACW+31:32]) ? '1 : shifted[31:0];

    logic        ovalid_reg;
    logic [31:0] odata_reg;
    logic [1:0]  ouser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.emit)
            ovalid_reg <= 1'b1;
        else if (m_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            odata_reg <= cost;
            ouser_reg <= {drop_reg, take_neg};
        end
    end

    assign stat.out_free = !ovalid_reg || m_tready;
    assign m_tvalid      = ovalid_reg;
    assign m_tdata       = odata_reg;
    assign m_tuser       = ouser_reg;

endmodule

[src/sw2_ctrl.sv]
`timescale 1ns / 1ps
module sw2_ctrl
    import sw2_pkg::*;
#(
    parameter int SET_DEPTH = DEPTH_DEF,
    localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1,
    localparam int CW = $clog2(SET_DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_accept,
    input  logic [1:0]    in_kind,
    input  stat_t         stat,
    input  logic [CW-1:0] ref_cnt,
    input  logic [CW-1:0] oth_cnt,
    output cmd_t          cmd,
    output logic [AW-1:0] addr_a,
    output logic [AW-1:0] addr_b,
    output logic          ready
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_NCHK  = 4'd1;
    localparam logic [3:0] ST_NDIV0 = 4'd2;
    localparam logic [3:0] ST_NDIV  = 4'd3;
    localparam logic [3:0] ST_SCHK  = 4'd4;
    localparam logic [3:0] ST_SLAT  = 4'd5;
    localparam logic [3:0] ST_SRD   = 4'd6;
    localparam logic [3:0] ST_SCMP  = 4'd7;
    localparam logic [3:0] ST_MINIT = 4'd8;
    localparam logic [3:0] ST_MRD   = 4'd9;
    localparam logic [3:0] ST_MLAT  = 4'd10;
    localparam logic [3:0] ST_MSTEP = 4'd11;
    localparam logic [3:0] ST_MMAC  = 4'd12;
    localparam logic [3:0] ST_MDONE = 4'd13;
    localparam logic [3:0] ST_EMIT  = 4'd14;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic          set_reg, set_next, neg_reg, neg_next;
    logic [CW-1:0] n_cur, j_rev;

    assign n_cur = set_reg ? oth_cnt : ref_cnt;
    assign j_rev = oth_cnt - 1'b1 - j_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            set_reg   <= 1'b0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            set_reg   <= set_next;
            neg_reg   <= neg_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        set_next   = set_reg;
        neg_next   = neg_reg;
        cmd        = '0;
        cmd.set_sel = set_reg;
        cmd.neg     = neg_reg;
        addr_a     = i_reg[AW-1:0];
        addr_b     = neg_reg ? j_rev[AW-1:0] : j_reg[AW-1:0];
        ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
                if (in_accept && in_kind == KIND_COMPUTE)
                begin
                    set_next   = 1'b0;
                    neg_next   = 1'b0;
                    i_next     = '0;
                    state_next = ST_NCHK;
                end
            end
            ST_NCHK:
            begin
                if (i_reg < n_cur)
                begin
                    cmd.rd_raw = 1'b1;
                    state_next = ST_NDIV0;
                end
                else
                begin
                    i_next     = '0;
                    state_next = ST_SCHK;
                end
            end
            ST_NDIV0:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_NDIV;
            end
            ST_NDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.wr_norm = 1'b1;
                    i_next      = i_reg + 1'b1;
                    state_next  = ST_NCHK;
                end
            end
            ST_SCHK:
            begin
                if (i_reg < n_cur)
                begin
                    cmd.rd_raw  = 1'b1;
                    cmd.rd_norm = 1'b1;
                    state_next  = ST_SLAT;
                end
                else if (!set_reg)
                begin
                    set_next   = 1'b1;
                    i_next     = '0;
                    state_next = ST_NCHK;
                end
                else
                    state_next = ST_MINIT;
            end
            ST_SLAT:
            begin
                cmd.lat_i  = 1'b1;
                j_next     = '0;
                state_next = ST_SRD;
            end
            ST_SRD:
            begin
                addr_a = j_reg[AW-1:0];
                if (j_reg < n_cur)
                begin
                    cmd.rd_raw = 1'b1;
                    state_next = ST_SCMP;
                end
                else
                begin
                    cmd.wr_sorted = 1'b1;
                    i_next        = i_reg + 1'b1;
                    state_next    = ST_SCHK;
                end
            end
            ST_SCMP:
            begin
                cmd.cmp_j   = 1'b1;
                cmd.earlier = j_reg < i_reg;
                j_next      = j_reg + 1'b1;
                state_next  = ST_SRD;
            end
            ST_MINIT:
            begin
                cmd.mw_init = 1'b1;
                i_next      = '0;
                j_next      = '0;
                if (ref_cnt == '0 || oth_cnt == '0)
                    state_next = ST_MDONE;
                else
                    state_next = ST_MRD;
            end
            ST_MRD:
            begin
                cmd.mw_rd  = 1'b1;
                state_next = ST_MLAT;
            end
            ST_MLAT:
            begin
                cmd.mw_lat = 1'b1;
                state_next = ST_MSTEP;
            end
            ST_MSTEP:
            begin
                cmd.mw_step = 1'b1;
                i_next      = i_reg + CW'(stat.adv_a);
                j_next      = j_reg + CW'(stat.adv_b);
                state_next  = ST_MMAC;
            end
            ST_MMAC:
            begin
                cmd.mw_mac = 1'b1;
                if (i_reg < ref_cnt && j_reg < oth_cnt)
                    state_next = ST_MRD;
                else
                    state_next = ST_MDONE;
            end
            ST_MDONE:
            begin
                if (!neg_reg)
                begin
                    cmd.save_plain = 1'b1;
                    neg_next       = 1'b1;
                    state_next     = ST_MINIT;
                end
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // The result waits here until the output register is free.
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

[src/signed_wasserstein2_1d.sv]
`timescale 1ns / 1ps
// Channel   Dir  Signals                     Contents
// s_*       in   tvalid tready tdata tuser   one sample load or a compute request
// m_*       out  tvalid tready tdata tuser   one cost result per compute request
//
// A compute request normalizes every reference and other sample with the
// serial divider, rank-sorts each set over one memory read port, and runs
// the merge walk twice (plain, then with the other set negated), plus setup.
// Reset is asynchronous and active low; the sample stores need no clearing.
// Input is stalled while a compute runs; a finished cost waits for the output
// register to be free, and that register holds it until m_tready.
module signed_wasserstein2_1d
    import sw2_pkg::*;
#(
    parameter int SET_DEPTH        = DEPTH_DEF,
    parameter int VALUE_BITS       = VALUE_DEF,
    parameter int WEIGHT_FRAC_BITS = WFRAC_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_value[15:0], sample_weight[31:16]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cost[31:0]
    output logic [1:0]  m_tuser    // use_negated[0], overflowed[1]
);

    localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CW = $clog2(SET_DEPTH + 1);

    cmd_t          cmd;
    stat_t         stat;
    logic [AW-1:0] addr_a, addr_b;
    logic [CW-1:0] ref_cnt, oth_cnt;
    logic          accept;

    assign accept = s_tvalid && s_tready;

    sw2_ctrl #(
        .SET_DEPTH (SET_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (accept),
        .in_kind   (s_tuser),
        .stat      (stat),
        .ref_cnt   (ref_cnt),
        .oth_cnt   (oth_cnt),
        .cmd       (cmd),
        .addr_a    (addr_a),
        .addr_b    (addr_b),
        .ready     (s_tready)
    );

    sw2_dp #(
        .SET_DEPTH        (SET_DEPTH),
        .VALUE_BITS       (VALUE_BITS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (accept),
        .in_kind   (s_tuser),
        .in_value  (s_tdata[15:0]),
        .in_weight (s_tdata[31:16]),
        .cmd       (cmd),
        .addr_a    (addr_a),
        .addr_b    (addr_b),
        .stat      (stat),
        .ref_cnt   (ref_cnt),
        .oth_cnt   (oth_cnt),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[src/sw2_checker.sv]
`timescale 1ns / 1ps
`include "signed_wasserstein2_1d_assert.svh"
module sw2_checker
    import sw2_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A result that is not taken stays in place.
    `SW2_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A compute transaction makes the block busy on the next cycle.
    `SW2_ASSERT_NEXT(a_compute_busy, s_tvalid && s_tready && s_tuser == KIND_COMPUTE, !s_tready)

    // A new result only appears at the end of a compute, when input was stalled.
    `SW2_ASSERT_SAME(a_result_after_busy, $rose(m_tvalid), $past(!s_tready))

endmodule

bind signed_wasserstein2_1d sw2_checker u_sw2_checker (.*);
